### rtl/csgpic_pkg.sv
// Package for the CSG point-in-cell test unit.
// Holds the surface kind, axis, request, parameter index and word codes, the
// controller state, command and status types. Depends on nothing.
`default_nettype none

package csgpic_pkg;

  localparam int unsigned NPARAM = 10;

  localparam logic [2:0] KIND_PLANE     = 3'd0;
  localparam logic [2:0] KIND_SPHERE    = 3'd1;
  localparam logic [2:0] KIND_CYLINDER  = 3'd2;
  localparam logic [2:0] KIND_CYL_TR    = 3'd3;
  localparam logic [2:0] KIND_CUBOID    = 3'd4;
  localparam logic [2:0] KIND_INF_PRISM = 3'd5;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_TEST  = 1'b1;

  localparam logic [3:0] PI_KIND  = 4'd0;
  localparam logic [3:0] PI_AXIS  = 4'd1;
  localparam logic [3:0] PI_WORD0 = 4'd2;
  localparam logic [3:0] PI_WORDN = 4'd11;

  localparam logic [3:0] W_CX  = 4'd0;
  localparam logic [3:0] W_CY  = 4'd1;
  localparam logic [3:0] W_CZ  = 4'd2;
  localparam logic [3:0] W_R   = 4'd3;
  localparam logic [3:0] W_PL1 = 4'd4;
  localparam logic [3:0] W_PL2 = 4'd5;
  localparam logic [3:0] W_PL3 = 4'd6;
  localparam logic [3:0] W_PL4 = 4'd7;
  localparam logic [3:0] W_PL5 = 4'd8;
  localparam logic [3:0] W_PL6 = 4'd9;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_DRAIN
  } state_e;

  typedef struct packed {
    logic       write;
    logic       load;
    logic       fetch;
    logic [3:0] word;
    logic       finish;
    logic       report;
  } dp_cmd_t;

  typedef struct packed {
    logic busy;
    logic last;
  } dp_status_t;

endpackage

`default_nettype wire

### rtl/csgpic_ctrl.sv
// Controller of the CSG point-in-cell test unit.
// Sequences table writes and the ten word reads of a test, and owns the
// output valid flag. Depends on csgpic_pkg.
`default_nettype none

module csgpic_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   req_type_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output csgpic_pkg::dp_cmd_t    cmd_o,
  input  csgpic_pkg::dp_status_t status_i
);
  import csgpic_pkg::*;

  state_e     state_q, state_d;
  logic [3:0] word_q, word_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;
  logic       slot_free;

  assign accept    = in_valid_i && (state_q == ST_IDLE);
  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    word_d  = word_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (req_type_i == REQ_TEST)) begin
          state_d = ST_FETCH;
          word_d  = W_CX;
        end
      end
      ST_FETCH: begin
        if (word_q == W_PL6) begin
          state_d = ST_DRAIN;
        end else begin
          word_d = word_q + 4'd1;
        end
      end
      ST_DRAIN: begin
        if (!status_i.busy && (!status_i.last || slot_free)) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    cmd_o.word  = word_q;
    in_ready_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.write = accept && (req_type_i == REQ_WRITE);
        cmd_o.load  = accept && (req_type_i == REQ_TEST);
      end
      ST_FETCH: begin
        cmd_o.fetch = 1'b1;
      end
      ST_DRAIN: begin
        if (!status_i.busy && (!status_i.last || slot_free)) begin
          cmd_o.finish = 1'b1;
          cmd_o.report = status_i.last;
        end
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.report) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      word_q      <= W_CX;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      word_q      <= word_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

### rtl/csgpic_datapath.sv
// Datapath of the CSG point-in-cell test unit.
// Holds the surface tables, the squarer and accumulator, the bound checks and
// the cell AND flag. Depends on csgpic_pkg.
`default_nettype none

module csgpic_datapath #(
  parameter int unsigned NUM_SURFACES = 64,
  parameter int unsigned COORD_BITS   = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  csgpic_pkg::dp_cmd_t    cmd_i,
  output csgpic_pkg::dp_status_t status_o,
  input  logic [5:0]             surf_index_i,
  input  logic [3:0]             param_index_i,
  input  logic signed [31:0]     param_value_i,
  input  logic                   term_out_i,
  input  logic                   term_last_i,
  input  logic signed [31:0]     point_x_i,
  input  logic signed [31:0]     point_y_i,
  input  logic signed [31:0]     point_z_i,
  output logic                   cell_inside_o
);
  import csgpic_pkg::*;

  localparam int unsigned EFF   = (COORD_BITS < 32) ? COORD_BITS : 32;
  localparam int unsigned IDX_W = $clog2(NUM_SURFACES);
  localparam int unsigned PDEP  = NUM_SURFACES * NPARAM;
  localparam int unsigned PA_W  = $clog2(PDEP);

  function automatic logic [PA_W-1:0] word_addr(input logic [IDX_W-1:0] s,
                                                 input logic [3:0] k);
    logic [IDX_W+4:0] sum;
    sum = {2'b00, s, 3'b000} + {4'b0000, s, 1'b0} + {{(IDX_W + 1){1'b0}}, k};
    return sum[PA_W-1:0];
  endfunction

  logic [2:0]     kind_mem [NUM_SURFACES];
  logic [1:0]     axis_mem [NUM_SURFACES];
  logic [EFF-1:0] param_mem [PDEP];

  logic [IDX_W+5:0] idx_ext;
  logic [IDX_W-1:0] idx_in;
  logic             idx_ok_in;
  logic [3:0]       wr_word;

  logic [IDX_W-1:0]   s_q;
  logic               range_ok_q;
  logic               term_out_q;
  logic               last_q;
  logic signed [31:0] pt_x_q, pt_y_q, pt_z_q;

  logic [2:0]     kind_q;
  logic [1:0]     axis_q;
  logic [EFF-1:0] pword_q;
  logic           vb_q;
  logic [3:0]     kb_q;

  logic [63:0] sq_q;
  logic        vc_q;
  logic        acc_en_q;
  logic        rad_c_q;

  logic [65:0] acc_q;
  logic [63:0] r2_q;
  logic        r_neg_q;
  logic        fail_q;
  logic        all_pass_q, all_pass_d;
  logic        cell_inside_q;

  logic [1:0]         ax, u_ax, v_ax, csel;
  logic               sq_en, rad_en, cmp_en, cmp_ge;
  logic signed [31:0] w, coord_sel, sq_a;
  logic signed [32:0] diff;
  logic [32:0]        mag;
  logic [63:0]        sq_d;
  logic               cmp_pass;
  logic               kind_ok, need_rad, rad_ok, surf_in, term_ok, and_now;

  assign idx_ext   = {{IDX_W{1'b0}}, surf_index_i};
  assign idx_in    = idx_ext[IDX_W-1:0];
  assign idx_ok_in = idx_ext < (IDX_W + 6)'(NUM_SURFACES);
  assign wr_word   = param_index_i - PI_WORD0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.write && idx_ok_in && (param_index_i == PI_KIND)) begin
      kind_mem[idx_in] <= param_value_i[2:0];
    end
    kind_q <= kind_mem[s_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.write && idx_ok_in && (param_index_i == PI_AXIS)) begin
      axis_mem[idx_in] <= param_value_i[1:0];
    end
    axis_q <= axis_mem[s_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.write && idx_ok_in && (param_index_i >= PI_WORD0) &&
        (param_index_i <= PI_WORDN)) begin
      param_mem[word_addr(idx_in, wr_word)] <= param_value_i[EFF-1:0];
    end
    if (cmd_i.fetch) begin
      pword_q <= param_mem[word_addr(s_q, cmd_i.word)];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      s_q        <= idx_in;
      range_ok_q <= idx_ok_in;
      term_out_q <= term_out_i;
      last_q     <= term_last_i;
      pt_x_q     <= 32'(signed'(point_x_i[EFF-1:0]));
      pt_y_q     <= 32'(signed'(point_y_i[EFF-1:0]));
      pt_z_q     <= 32'(signed'(point_z_i[EFF-1:0]));
    end
  end

  assign ax   = (axis_q > AXIS_Z) ? AXIS_Z : axis_q;
  assign u_ax = (ax == AXIS_X) ? AXIS_Y : AXIS_X;
  assign v_ax = (ax == AXIS_Z) ? AXIS_Y : AXIS_Z;
  assign w    = 32'(signed'(pword_q));

  always_comb begin
    sq_en  = 1'b0;
    rad_en = 1'b0;
    cmp_en = 1'b0;
    cmp_ge = 1'b0;
    csel   = ax;
    case (kind_q)
      KIND_PLANE: begin
        if (kb_q == W_PL1) begin
          cmp_en = 1'b1;
        end
      end
      KIND_SPHERE: begin
        case (kb_q)
          W_CX, W_CY, W_CZ: begin
            sq_en = 1'b1;
            csel  = kb_q[1:0];
          end
          W_R: rad_en = 1'b1;
          default: sq_en = 1'b0;
        endcase
      end
      KIND_CYLINDER, KIND_CYL_TR: begin
        case (kb_q)
          W_CX: begin
            sq_en = 1'b1;
            csel  = u_ax;
          end
          W_CY: begin
            sq_en = 1'b1;
            csel  = v_ax;
          end
          W_R: rad_en = 1'b1;
          W_PL1: cmp_en = (kind_q == KIND_CYL_TR);
          W_PL2: begin
            cmp_en = (kind_q == KIND_CYL_TR);
            cmp_ge = 1'b1;
          end
          default: sq_en = 1'b0;
        endcase
      end
      KIND_CUBOID: begin
        cmp_en = 1'b1;
        case (kb_q)
          W_PL1: begin
            cmp_ge = 1'b1;
            csel   = AXIS_X;
          end
          W_PL2: begin
            cmp_ge = 1'b1;
            csel   = AXIS_Y;
          end
          W_PL3: begin
            cmp_ge = 1'b1;
            csel   = AXIS_Z;
          end
          W_PL4: csel = AXIS_X;
          W_PL5: csel = AXIS_Y;
          W_PL6: csel = AXIS_Z;
          default: cmp_en = 1'b0;
        endcase
      end
      KIND_INF_PRISM: begin
        cmp_en = 1'b1;
        case (kb_q)
          W_PL1: begin
            cmp_ge = 1'b1;
            csel   = u_ax;
          end
          W_PL2: begin
            cmp_ge = 1'b1;
            csel   = v_ax;
          end
          W_PL3: csel = u_ax;
          W_PL4: csel = v_ax;
          default: cmp_en = 1'b0;
        endcase
      end
      default: cmp_en = 1'b0;
    endcase
  end

  always_comb begin
    case (csel)
      AXIS_X:  coord_sel = pt_x_q;
      AXIS_Y:  coord_sel = pt_y_q;
      default: coord_sel = pt_z_q;
    endcase
  end

  assign cmp_pass = cmp_ge ? (coord_sel >= w) : (coord_sel <= w);
  assign sq_a     = rad_en ? 32'sd0 : coord_sel;
  assign diff     = 33'(sq_a) - 33'(w);
  assign mag      = diff[32] ? (33'd0 - 33'(diff)) : 33'(diff);
  assign sq_d     = mag[31:0] * mag[31:0];

  always_ff @(posedge clk_i) begin
    if (vb_q) begin
      sq_q     <= sq_d;
      acc_en_q <= sq_en;
      rad_c_q  <= rad_en;
    end
    if (cmd_i.load) begin
      acc_q   <= '0;
      fail_q  <= 1'b0;
      r_neg_q <= 1'b0;
    end else begin
      if (vb_q && cmp_en && !cmp_pass) begin
        fail_q <= 1'b1;
      end
      if (vb_q && rad_en) begin
        r_neg_q <= w[31];
      end
      if (vc_q && acc_en_q) begin
        acc_q <= acc_q + 66'(sq_q);
      end
    end
    if (vc_q && rad_c_q) begin
      r2_q <= sq_q;
    end
    if (cmd_i.report) begin
      cell_inside_q <= and_now;
    end
  end

  assign kind_ok  = kind_q <= KIND_INF_PRISM;
  assign need_rad = (kind_q == KIND_SPHERE) || (kind_q == KIND_CYLINDER) ||
                    (kind_q == KIND_CYL_TR);
  assign rad_ok   = !r_neg_q && ((kind_q == KIND_SPHERE) ? (66'(r2_q) > acc_q)
                                                        : (66'(r2_q) >= acc_q));
  assign surf_in  = range_ok_q && kind_ok && !fail_q && (!need_rad || rad_ok);
  assign term_ok  = surf_in ^ term_out_q;
  assign and_now  = all_pass_q && term_ok;

  always_comb begin
    all_pass_d = all_pass_q;
    if (cmd_i.finish) begin
      all_pass_d = cmd_i.report ? 1'b1 : and_now;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q       <= 1'b0;
      kb_q       <= W_CX;
      vc_q       <= 1'b0;
      all_pass_q <= 1'b1;
    end else begin
      vb_q       <= cmd_i.fetch;
      kb_q       <= cmd_i.word;
      vc_q       <= vb_q;
      all_pass_q <= all_pass_d;
    end
  end

  assign status_o.busy = vb_q || vc_q;
  assign status_o.last = last_q;
  assign cell_inside_o = cell_inside_q;

endmodule

`default_nettype wire

### rtl/csg_point_in_cell_test_unit.sv
// Top level of the CSG point-in-cell test unit.
// Joins the controller and the datapath. Depends on csgpic_pkg, csgpic_ctrl
// and csgpic_datapath.
//
//   Channel | Handshake            | Payload
//   --------+----------------------+-----------------------------------------
//   in      | in_valid_i/in_ready_o| req_type, surf_index, param_index,
//           |                      | param_value, term_out, term_last, point
//   out     | out_valid_o/out_ready| cell_inside
//
// A write transaction leaves the controller idle, so the unit stays ready. A
// test transaction reads the ten parameter words of the entry one per cycle
// from the parameter memory, then drains the squarer and accumulator
// pipeline before the next ready. After reset the surface tables
// hold nothing defined and are not cleared; each entry must be written first.
// The result register lets new transactions be accepted while a result waits;
// a last term stalls only while the previous result has not been taken.
`default_nettype none

module csg_point_in_cell_test_unit #(
  parameter int unsigned NUM_SURFACES = 64,
  parameter int unsigned COORD_BITS   = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               req_type_i,
  input  logic [5:0]         surf_index_i,
  input  logic [3:0]         param_index_i,
  input  logic signed [31:0] param_value_i,
  input  logic               term_out_i,
  input  logic               term_last_i,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  input  logic signed [31:0] point_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               cell_inside_o
);
  import csgpic_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  csgpic_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  csgpic_datapath #(
    .NUM_SURFACES (NUM_SURFACES),
    .COORD_BITS   (COORD_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .surf_index_i  (surf_index_i),
    .param_index_i (param_index_i),
    .param_value_i (param_value_i),
    .term_out_i    (term_out_i),
    .term_last_i   (term_last_i),
    .point_x_i     (point_x_i),
    .point_y_i     (point_y_i),
    .point_z_i     (point_z_i),
    .cell_inside_o (cell_inside_o)
  );

endmodule

`default_nettype wire
